// ===== hw/rtl/hri_pkg.sv =====
// Package for the histogram range integrator: item types, register indexes,
// sequencer states and fixed-point constants. No dependencies.
package hri_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned CntW     = 6;

  localparam logic [32:0] OneQ = 33'(1) << FracBits;

  typedef enum logic [2:0] {
    CFG_LOWER_LIMIT     = 3'd0,
    CFG_UPPER_LIMIT     = 3'd1,
    CFG_INCLUDE_PARTIAL = 3'd2,
    CFG_IS_DISTRIBUTION = 3'd3,
    CFG_HAS_FRACTION    = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WDIV,
    ST_MUL_V,
    ST_MUL_E,
    ST_MUL_T,
    ST_MUL_F,
    ST_ACC,
    ST_SQRT,
    ST_MDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] bin_low_edge;
    logic signed [31:0] bin_high_edge;
    logic signed [31:0] bin_value;
    logic [30:0]        bin_error;
    logic [31:0]        area_fraction;
    logic               last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] sum_value;
    logic [31:0]        sum_error;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [31:0]        mean_fraction;
    logic               overlap_found;
  } out_item_t;

endpackage

// ===== hw/rtl/histogram_range_integrator.sv =====
// Histogram range integrator top level: sequencer around one shared multiplier,
// one shared restoring divider and a bit-pair square root. Depends on hri_pkg.
//
//  channel  direction  handshake            payload
//  in       input      in_valid_i/in_stall_o   hri_pkg::in_item_t
//  out      output     out_valid_o/out_stall_i hri_pkg::out_item_t
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A bin outside the range only updates the edge tracking, an inside bin runs
// the multiply states, and a cut bin of count data first finds its weight by
// division on the shared divider. The last bin adds the square root, a mean
// division when one is needed and the load of the output register.
// Reset clears configuration to no limits and all accumulators to zero.
// A result waits in the output register while the next bins stream in; only
// a further last bin waits for it to be taken.
module histogram_range_integrator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hri_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hri_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned F = hri_pkg::FracBits;
  localparam int unsigned CntW_ = hri_pkg::CntW;

  // configuration
  logic signed [31:0] lower_q, upper_q;
  logic partial_q, dist_q, hasfrac_q;

  hri_pkg::state_e state_q, state_d;

  // latched item
  logic signed [31:0] y_q, y_d;
  logic [30:0] e_q, e_d;
  logic [31:0] f_q, f_d;
  logic last_q, last_d;

  // weights and multiplier
  logic signed [32:0] wv_q, wv_d;
  logic [31:0] wf_q, wf_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q, prod_d;
  logic tbig_q, tbig_d;

  // accumulators
  logic signed [63:0] acc_value_q, acc_value_d;
  logic [63:0] acc_err_q, acc_err_d;
  logic [63:0] acc_frac_q, acc_frac_d;
  logic [47:0] acc_norm_q, acc_norm_d;
  logic signed [31:0] first_q, first_d, lastedge_q, lastedge_d;
  logic seen_q, seen_d, upok_q, upok_d;

  // divider
  logic [48:0] dv_rem_q, dv_rem_d;
  logic [47:0] dv_div_q, dv_div_d;
  logic [31:0] dv_low_q, dv_low_d, dv_quo_q, dv_quo_d;
  logic [CntW_-1:0] cnt_q, cnt_d;

  // square root
  logic [63:0] sq_v_q, sq_v_d, sq_r_q, sq_r_d, sq_bit_q, sq_bit_d;
  logic [31:0] mean_q, mean_d;

  logic out_valid_q, out_valid_d;
  hri_pkg::out_item_t out_q, out_d;

  logic in_acc, range_ok, load_out;

  assign in_stall_o  = (state_q != hri_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign range_ok    = (upper_q >= lower_q);
  assign load_out    = (state_q == hri_pkg::ST_DONE) && !(out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q   <= 32'sh8000_0000;
      upper_q   <= 32'sh7fff_ffff;
      partial_q <= 1'b0;
      dist_q    <= 1'b0;
      hasfrac_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hri_pkg::CFG_LOWER_LIMIT:     lower_q   <= cfg_data_i;
        hri_pkg::CFG_UPPER_LIMIT:     upper_q   <= cfg_data_i;
        hri_pkg::CFG_INCLUDE_PARTIAL: partial_q <= cfg_data_i[0];
        hri_pkg::CFG_IS_DISTRIBUTION: dist_q    <= cfg_data_i[0];
        hri_pkg::CFG_HAS_FRACTION:    hasfrac_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hri_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      acc_value_q <= '0;
      acc_err_q   <= '0;
      acc_frac_q  <= '0;
      acc_norm_q  <= '0;
      first_q     <= '0;
      lastedge_q  <= '0;
      seen_q      <= 1'b0;
      upok_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_value_q <= acc_value_d;
      acc_err_q   <= acc_err_d;
      acc_frac_q  <= acc_frac_d;
      acc_norm_q  <= acc_norm_d;
      first_q     <= first_d;
      lastedge_q  <= lastedge_d;
      seen_q      <= seen_d;
      upok_q      <= upok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q      <= y_d;
    e_q      <= e_d;
    f_q      <= f_d;
    last_q   <= last_d;
    wv_q     <= wv_d;
    wf_q     <= wf_d;
    prod_q   <= prod_d;
    tbig_q   <= tbig_d;
    dv_rem_q <= dv_rem_d;
    dv_div_q <= dv_div_d;
    dv_low_q <= dv_low_d;
    dv_quo_q <= dv_quo_d;
    cnt_q    <= cnt_d;
    sq_v_q   <= sq_v_d;
    sq_r_q   <= sq_r_d;
    sq_bit_q <= sq_bit_d;
    mean_q   <= mean_d;
    out_q    <= out_d;
  end

  // shared multiplier
  assign prod_d = 66'(mul_a) * 66'(mul_b);

  always_comb begin
    logic signed [32:0] lo, hi, lw, up, ov, width;
    logic in_range, cut_both, cut_low, cut_up, cut;
    logic [48:0] r2;
    logic ge;
    logic [63:0] sum_rb;
    logic [63:0] mean_init;
    logic signed [64:0] ssum;
    logic [64:0] usum;
    logic [48:0] nsum;
    logic [32:0] aw;

    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    y_d = y_q; e_d = e_q; f_d = f_q; last_d = last_q;
    wv_d = wv_q; wf_d = wf_q; tbig_d = tbig_q;
    acc_value_d = acc_value_q; acc_err_d = acc_err_q;
    acc_frac_d = acc_frac_q; acc_norm_d = acc_norm_q;
    first_d = first_q; lastedge_d = lastedge_q; seen_d = seen_q; upok_d = upok_q;
    dv_rem_d = dv_rem_q; dv_div_d = dv_div_q; dv_low_d = dv_low_q; dv_quo_d = dv_quo_q;
    cnt_d = cnt_q;
    sq_v_d = sq_v_q; sq_r_d = sq_r_q; sq_bit_d = sq_bit_q;
    mean_d = mean_q;
    mul_a = '0; mul_b = '0;

    lo = 33'(in_item_i.bin_low_edge);
    hi = 33'(in_item_i.bin_high_edge);
    lw = 33'(lower_q);
    up = 33'(upper_q);
    in_range = (lo >= lw) && (hi <= up);
    cut_both = (lo < lw) && (up < hi);
    cut_low  = (lo < lw) && (lw <= hi) && (hi <= up);
    cut_up   = (lo >= lw) && (lo <= up) && (up < hi);
    cut      = partial_q && !in_range && (cut_both || cut_low || cut_up);
    ov       = cut_both ? (up - lw) : (cut_low ? (hi - lw) : (up - lo));
    width    = hi - lo;

    // one divider step
    r2 = {dv_rem_q[47:0], dv_low_q[31]};
    ge = (r2 >= {1'b0, dv_div_q});

    sum_rb    = sq_r_q + sq_bit_q;
    mean_init = acc_frac_q >> (32 - F);
    aw        = wv_q[32] ? 33'(-wv_q) : 33'(wv_q);
    ssum      = 65'(acc_value_q) + 65'(signed'(prod_q[63:0]));
    usum      = '0;
    nsum      = '0;

    case (state_q)
      hri_pkg::ST_IDLE: begin
        if (in_acc) begin
          y_d    = in_item_i.bin_value;
          e_d    = in_item_i.bin_error;
          f_d    = in_item_i.area_fraction;
          last_d = in_item_i.last_bin;
          if (range_ok) begin
            if (!seen_q && (lo >= lw)) begin
              first_d = in_item_i.bin_low_edge;
              seen_d  = 1'b1;
            end else if (!seen_q && (hi >= lw)) begin
              first_d = in_item_i.bin_high_edge;
              seen_d  = 1'b1;
            end
            if (hi <= up) begin
              lastedge_d = in_item_i.bin_high_edge;
              upok_d     = 1'b1;
            end else if (lo <= up) begin
              lastedge_d = in_item_i.bin_low_edge;
              upok_d     = 1'b1;
            end
          end
          if (range_ok && in_range) begin
            wv_d    = dist_q ? width : hri_pkg::OneQ;
            wf_d    = 32'(hri_pkg::OneQ);
            state_d = hri_pkg::ST_MUL_V;
          end else if (range_ok && cut && dist_q) begin
            wv_d    = ov;
            wf_d    = ov[31:0];
            state_d = hri_pkg::ST_MUL_V;
          end else if (range_ok && cut) begin
            // weight = floor(ov * 2^F / width), quotient has F+1 bits
            dv_rem_d = 49'(ov[31:1]);
            dv_div_d = 48'(width[31:0]);
            dv_low_d = {ov[0], 31'd0};
            dv_quo_d = '0;
            cnt_d    = CntW_'(F);
            state_d  = hri_pkg::ST_WDIV;
          end else if (in_item_i.last_bin) begin
            sq_v_d   = acc_err_q;
            sq_r_d   = '0;
            sq_bit_d = 64'd1 << 62;
            cnt_d    = CntW_'(31);
            state_d  = hri_pkg::ST_SQRT;
          end
        end
      end
      hri_pkg::ST_WDIV: begin
        dv_rem_d = ge ? (r2 - {1'b0, dv_div_q}) : r2;
        dv_low_d = dv_low_q << 1;
        dv_quo_d = {dv_quo_q[30:0], ge};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          wv_d    = 33'(dv_quo_d[F:0]);
          wf_d    = 32'(dv_quo_d[F:0]);
          state_d = hri_pkg::ST_MUL_V;
        end
      end
      hri_pkg::ST_MUL_V: begin
        mul_a   = 33'(y_q);
        mul_b   = wv_q;
        state_d = hri_pkg::ST_MUL_E;
      end
      hri_pkg::ST_MUL_E: begin
        if (ssum[64] != ssum[63]) begin
          acc_value_d = ssum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        end else begin
          acc_value_d = ssum[63:0];
        end
        mul_a   = {2'b00, e_q};
        mul_b   = aw;
        state_d = hri_pkg::ST_MUL_T;
      end
      hri_pkg::ST_MUL_T: begin
        // t = product >> F; saturate the squared sum if t exceeds 32 bits
        tbig_d  = (prod_q[65:32+F] != '0);
        mul_a   = {1'b0, prod_q[F+31:F]};
        mul_b   = {1'b0, prod_q[F+31:F]};
        state_d = hri_pkg::ST_MUL_F;
      end
      hri_pkg::ST_MUL_F: begin
        usum = 65'(acc_err_q) + 65'(prod_q[63:0]);
        if (tbig_q || usum[64]) begin
          acc_err_d = '1;
        end else begin
          acc_err_d = usum[63:0];
        end
        mul_a   = {1'b0, f_q};
        mul_b   = {1'b0, wf_q};
        state_d = hri_pkg::ST_ACC;
      end
      hri_pkg::ST_ACC: begin
        if (hasfrac_q) begin
          usum = 65'(acc_frac_q) + 65'(prod_q[63:0] >> F);
          acc_frac_d = usum[64] ? '1 : usum[63:0];
          if (f_q != '0) begin
            nsum = 49'(acc_norm_q) + 49'(wf_q);
            acc_norm_d = nsum[48] ? '1 : nsum[47:0];
          end
        end
        if (last_q) begin
          sq_v_d   = acc_err_d;
          sq_r_d   = '0;
          sq_bit_d = 64'd1 << 62;
          cnt_d    = CntW_'(31);
          state_d  = hri_pkg::ST_SQRT;
        end else begin
          state_d = hri_pkg::ST_IDLE;
        end
      end
      hri_pkg::ST_SQRT: begin
        if (sq_v_q >= sum_rb) begin
          sq_v_d = sq_v_q - sum_rb;
          sq_r_d = (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_d = sq_r_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = hri_pkg::ST_DONE;
          if (!hasfrac_q) begin
            mean_d = '0;
          end else if (acc_norm_q == '0) begin
            mean_d = (acc_frac_q[63:32] != '0) ? '1 : acc_frac_q[31:0];
          end else if (mean_init >= 64'(acc_norm_q)) begin
            mean_d = '1;
          end else begin
            dv_rem_d = 49'(mean_init);
            dv_div_d = acc_norm_q;
            dv_low_d = acc_frac_q[31:0] << F;
            dv_quo_d = '0;
            cnt_d    = CntW_'(31);
            state_d  = hri_pkg::ST_MDIV;
          end
        end
      end
      hri_pkg::ST_MDIV: begin
        dv_rem_d = ge ? (r2 - {1'b0, dv_div_q}) : r2;
        dv_low_d = dv_low_q << 1;
        dv_quo_d = {dv_quo_q[30:0], ge};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          mean_d  = dv_quo_d;
          state_d = hri_pkg::ST_DONE;
        end
      end
      hri_pkg::ST_DONE: begin
        if (load_out) begin
          out_d.sum_value     = acc_value_q;
          out_d.sum_error     = sq_r_q[31:0];
          out_d.mean_fraction = mean_q;
          out_d.overlap_found = range_ok && seen_q && upok_q;
          if (range_ok && partial_q) begin
            out_d.range_low  = lower_q;
            out_d.range_high = upper_q;
          end else if (range_ok && seen_q && upok_q) begin
            out_d.range_low  = first_q;
            out_d.range_high = lastedge_q;
          end else begin
            out_d.range_low  = '0;
            out_d.range_high = '0;
          end
          out_valid_d = 1'b1;
          acc_value_d = '0;
          acc_err_d   = '0;
          acc_frac_d  = '0;
          acc_norm_d  = '0;
          first_d     = '0;
          lastedge_d  = '0;
          seen_d      = 1'b0;
          upok_d      = 1'b0;
          state_d     = hri_pkg::ST_IDLE;
        end
      end
      default: state_d = hri_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_last_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.last_bin) |=> (state_q != hri_pkg::ST_IDLE))
    else $error("last bin did not start the result sequence");

  a_sqrt_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hri_pkg::ST_SQRT) |-> $onehot(sq_bit_q))
    else $error("square root bit lost its single set bit");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hri_pkg::ST_WDIV || state_q == hri_pkg::ST_MDIV)
      |-> (dv_rem_q < {1'b0, dv_div_q}))
    else $error("divider remainder not below divisor");

  a_clear_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && acc_value_q == '0 && !seen_q && !upok_q))
    else $error("accumulators not cleared after result load");
`endif

endmodule

// ===== verif/histogram_range_integrator_tb.sv =====
// Self-checking testbench for histogram_range_integrator: streams histograms under several
// limit and mode settings, predicts each result in-line and compares it field by field.
// Depends on hri_pkg and the histogram_range_integrator RTL.
`timescale 1ns / 100ps

module histogram_range_integrator_tb;

  localparam int unsigned FB        = 16;
  localparam int unsigned WdogLimit = 3000;
  localparam int unsigned Drain     = 120;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  hri_pkg::in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  hri_pkg::out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  histogram_range_integrator dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- predictor state ----------------
  logic signed [31:0] lim_lo, lim_hi;
  bit         part_en, dens_en, frac_en;
  longint     acc_sum;
  bit [63:0]  acc_err2, acc_frac, acc_norm;
  longint     first_edge, last_edge;
  bit         seen_lo_ok, seen_hi_ok;

  hri_pkg::out_item_t  pending_results[$];
  int unsigned n_fail;
  int unsigned idle_cycles;
  int unsigned out_hold_left;
  bit          send_burst;

  function automatic logic [31:0] q(int v);
    return 32'(v <<< FB);
  endfunction

  function automatic void clear_sums();
    acc_sum = 0; acc_err2 = '0; acc_frac = '0; acc_norm = '0;
    first_edge = 0; last_edge = 0; seen_lo_ok = 0; seen_hi_ok = 0;
  endfunction

  function automatic bit [63:0] add_sat_u(bit [63:0] a, bit [63:0] b);
    bit [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic void add_share(longint y, bit [63:0] e, bit [63:0] f,
                                    longint wv, bit [63:0] wf);
    bit [63:0] aw, t;
    longint p;
    logic signed [64:0] s;
    aw = (wv < 0) ? 64'(-wv) : 64'(wv);
    t  = (e * aw) >> FB;
    p  = y * wv;
    s  = 65'(acc_sum) + 65'(p);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc_sum = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (s < -65'sh0_8000_0000_0000_0000) acc_sum = 64'h8000_0000_0000_0000;
    else acc_sum = s[63:0];
    if (t > 64'hFFFF_FFFF) acc_err2 = '1;
    else acc_err2 = add_sat_u(acc_err2, t * t);
    if (frac_en) begin
      acc_frac = add_sat_u(acc_frac, (f * wf) >> FB);
      if (f != 0) begin
        acc_norm = acc_norm + wf;
        if (acc_norm > 64'hFFFF_FFFF_FFFF) acc_norm = 64'hFFFF_FFFF_FFFF;
      end
    end
  endfunction

  function automatic void note_edge(longint x);
    if (x >= longint'(lim_lo) && !seen_lo_ok) begin
      first_edge = x; seen_lo_ok = 1;
    end
    if (x <= longint'(lim_hi)) begin
      last_edge = x; seen_hi_ok = 1;
    end
  endfunction

  function automatic bit [31:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic bit [31:0] mean_fraction();
    bit [63:0] n, s, qt, rm;
    n = acc_norm; s = acc_frac;
    if (!frac_en) return '0;
    if (n == 0) return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    qt = s / n;
    if (qt >= (64'd1 << (32 - FB))) return 32'hFFFF_FFFF;
    rm = s % n;
    for (int i = 0; i < FB; i++) begin
      rm <<= 1; qt <<= 1;
      if (rm >= n) begin
        rm -= n; qt |= 1;
      end
    end
    return qt[31:0];
  endfunction

  // Folds one bin into the running sums; returns 1 with the result on a last bin.
  function automatic bit integrate_bin(hri_pkg::in_item_t b, output hri_pkg::out_item_t r);
    longint lo, hi, y, lv, uv, ov, wd;
    bit [63:0] w;
    bit ok, hit;
    lo = b.bin_low_edge; hi = b.bin_high_edge; y = b.bin_value;
    lv = lim_lo; uv = lim_hi;
    ok = uv >= lv;
    r = '0;
    if (ok) begin
      note_edge(lo);
      note_edge(hi);
      if (lo >= lv && hi <= uv) begin
        wd = dens_en ? hi - lo : longint'(1) << FB;
        add_share(y, 64'(b.bin_error), 64'(b.area_fraction), wd, 64'd1 << FB);
      end else if (part_en) begin
        ov = -1;
        if (lo < lv && uv < hi) ov = uv - lv;
        else if (lo < lv && lv <= hi && hi <= uv) ov = hi - lv;
        else if (lo >= lv && lo <= uv && uv < hi) ov = uv - lo;
        if (ov >= 0) begin
          w = 64'(ov);
          if (!dens_en) w = (w << FB) / 64'(hi - lo);
          add_share(y, 64'(b.bin_error), 64'(b.area_fraction), longint'(w), w);
        end
      end
    end
    if (!b.last_bin) return 0;
    hit = ok && seen_lo_ok && seen_hi_ok;
    if (ok && part_en) begin
      r.range_low = lim_lo; r.range_high = lim_hi;
    end else if (hit) begin
      r.range_low = 32'(first_edge); r.range_high = 32'(last_edge);
    end
    r.sum_value     = acc_sum;
    r.sum_error     = int_sqrt(acc_err2);
    r.mean_fraction = mean_fraction();
    r.overlap_found = hit;
    clear_sums();
    return 1;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(hri_pkg::in_item_t b);
    hri_pkg::out_item_t r;
    int unsigned gap, sel;
    @(negedge clk_i);
    in_item_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (integrate_bin(b, r)) pending_results.push_back(r);
    sel = $urandom_range(0, 99);
    if (send_burst || sel < 60) gap = 0;
    else if (sel < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(15, 60);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_bin(logic [31:0] lo, logic [31:0] hi, logic [31:0] val,
                          logic [30:0] err, logic [31:0] frac, bit last);
    hri_pkg::in_item_t b;
    b.bin_low_edge = lo; b.bin_high_edge = hi; b.bin_value = val;
    b.bin_error = err; b.area_fraction = frac; b.last_bin = last;
    send_item(b);
  endtask

  task automatic write_reg(hri_pkg::cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [31:0] lo, logic [31:0] hi, bit part, bit dens, bit frac);
    wait_drained();
    write_reg(hri_pkg::CFG_LOWER_LIMIT, lo);
    write_reg(hri_pkg::CFG_UPPER_LIMIT, hi);
    write_reg(hri_pkg::CFG_INCLUDE_PARTIAL, {31'($urandom), part});
    write_reg(hri_pkg::CFG_IS_DISTRIBUTION, {31'($urandom), dens});
    write_reg(hri_pkg::CFG_HAS_FRACTION, {31'($urandom), frac});
    lim_lo = lo; lim_hi = hi; part_en = part; dens_en = dens; frac_en = frac;
  endtask

  // One well-formed histogram of ascending bins with random content.
  task automatic send_histogram(int unsigned nbins, bit wide);
    longint bin_edge, w;
    logic [31:0] val, frac;
    logic [30:0] err;
    bin_edge = wide ? longint'($signed($urandom)) / 2
                    : longint'($signed(q($urandom_range(0, 60)))) - longint'($signed(q(30)));
    for (int i = 0; i < nbins; i++) begin
      w = wide ? longint'($urandom_range(1, 32'h3FFF_FFFF))
               : longint'($urandom_range(1, 32'h0006_0000));
      if (bin_edge + w > 64'sh7FFF_FFFF) w = 1;
      val  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed(q(10)) - $urandom_range(0, q(20)));
      err  = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, q(4)));
      case ($urandom_range(0, 3))
        0: frac = '0;
        1: frac = $urandom;
        default: frac = $urandom_range(0, q(1));
      endcase
      send_bin(32'(bin_edge), 32'(bin_edge + w), val, err, frac, i == nbins - 1);
      bin_edge = bin_edge + w;
    end
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    int unsigned run_left, sel;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (out_hold_left > 0) begin
        out_stall_i <= 1'b1;
        out_hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          out_stall_i <= 1'b0; run_left = $urandom_range(0, 20);
        end else if (sel < 92) begin
          out_stall_i <= 1'b1; run_left = $urandom_range(0, 2);
        end else begin
          out_stall_i <= 1'b1; run_left = $urandom_range(20, 80);
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      n_fail++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    hri_pkg::out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result: expected none, actual %h", $time, out_item_o);
      end else begin
        e = pending_results.pop_front();
        check_field("sum_value", e.sum_value, out_item_o.sum_value);
        check_field("sum_error", e.sum_error, out_item_o.sum_error);
        check_field("range_low", e.range_low, out_item_o.range_low);
        check_field("range_high", e.range_high, out_item_o.range_high);
        check_field("mean_fraction", e.mean_fraction, out_item_o.mean_fraction);
        check_field("overlap_found", e.overlap_found, out_item_o.overlap_found);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    // no limits, count data, no fraction
    send_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, 1);
    send_bin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1, 0);
    send_bin(q(-3), q(-1), 32'h8000_0000, '1, '0, 1);
  endtask

  task automatic test_cut_bins();
    set_mode(q(2), q(5), 1, 0, 1);
    send_bin(q(1), q(3), q(4), q(1), q(1), 0);      // lower cut
    send_bin(q(3), q(4), q(2), q(2), '0, 0);        // inside
    send_bin(q(4), q(8), q(1), q(1), q(1) >> 1, 1); // upper cut
    send_bin(q(0), q(9), q(3), '1, '1, 1);          // both limits in one bin
    send_bin(q(6), q(9), q(3), q(1), q(1), 1);      // no overlap, range = limits
    set_mode(q(2), q(5), 0, 0, 1);
    send_bin(q(6), q(9), q(3), q(1), q(1), 1);      // no overlap, range zero
    send_bin(q(4), q(3), q(1), q(1), '0, 0);        // reversed bin
    send_bin(q(3), q(4), q(1), q(1), '0, 1);        // fraction weight zero
  endtask

  task automatic test_distribution();
    set_mode(q(-10), q(10), 1, 1, 1);
    send_bin(q(3), q(1), q(5), q(1), q(1), 0);      // negative width inside
    send_bin(q(-12), q(-8), 32'h8000_0000, '1, '1, 0);
    send_bin(q(8), q(20), 32'h7FFF_FFFF, '1, '1, 1);
    set_mode(q(5), q(-5), 1, 1, 1);                 // inverted limits
    send_bin(q(-1), q(1), q(5), q(1), q(1), 1);
    set_mode(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 0);
    send_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, 1);
  endtask

  task automatic test_backpressure();
    set_mode(q(-20), q(20), 1, 0, 1);
    out_hold_left = 400;
    send_burst = 1;
    for (int i = 0; i < 6; i++) send_histogram($urandom_range(1, 3), 0);
    send_burst = 0;
  endtask

  task automatic test_random();
    logic [31:0] a, b;
    for (int ph = 0; ph < 12; ph++) begin
      a = q($urandom_range(0, 40)) - q(25);
      b = a + $urandom_range(0, q(30));
      if (ph % 4 == 3) begin
        a = $urandom; b = $urandom;
      end
      set_mode(a, b, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      for (int n = 0; n < 65; ) begin
        int unsigned k;
        k = $urandom_range(1, 9);
        if ($urandom_range(0, 9) == 0) begin
          // noise: unsorted bins with arbitrary fields
          for (int i = 0; i < k; i++)
            send_bin($urandom, $urandom, $urandom, 31'($urandom), $urandom, i == k - 1);
        end else begin
          send_histogram(k, $urandom_range(0, 7) == 0);
        end
        n += k;
      end
    end
  endtask

  initial begin
    n_fail = 0; idle_cycles = 0; out_hold_left = 0; send_burst = 0;
    lim_lo = 32'h8000_0000; lim_hi = 32'h7FFF_FFFF;
    part_en = 0; dens_en = 0; frac_en = 0;
    clear_sums();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_cut_bins();
    test_distribution();
    test_backpressure();
    test_random();
    wait_drained();
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
